>>> rtl/pcf_pkg.sv
// Shared types and constants of the periodic cubic fit block.
// Used by pcf_div, pcf_mul and periodic_cubic_fit_derivatives; depends on nothing.
package pcf_pkg;

	// fraction bits of an angle (Q3.29); quotients and products are scaled by it
	localparam int unsigned FRAC = 29;
	// magnitude widths: dividend, divisor, quotient / product
	localparam int unsigned NW = 62;
	localparam int unsigned XW = 35;
	localparam int unsigned QW = 61;
	// multiplier operand widths
	localparam int unsigned MA = 61;
	localparam int unsigned MB = 35;

	localparam logic [33:0] TWO_PI     = 34'd3373259426;
	localparam logic [31:0] QUARTER_PI = 32'd421657428;
	localparam logic [31:0] HIGH_EDGE  = 32'd2951601998; // 2*pi - pi/4

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic CFG_GRID_SPACING = 1'b0;
	localparam logic CFG_NODE_COUNT   = 1'b1;

	typedef struct packed {
		logic          start;
		logic          frac;   // 1: floor(n * 2^29 / x), 0: floor(n / x)
		logic [NW-1:0] n;
		logic [XW-1:0] x;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic [QW-1:0] q;      // saturated to 2^61 - 1
	} div_rsp_t;

	typedef struct packed {
		logic          start;
		logic [MA-1:0] a;
		logic [MB-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic          done;
		logic [QW-1:0] m;      // floor(a * b / 2^29), saturated
	} mul_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KDIV,
		ST_KWAIT,
		ST_KSET,
		ST_READ,
		ST_RLAST,
		ST_PREP,
		ST_CHECK,
		ST_DDIV,
		ST_DWAIT,
		ST_HMUL,
		ST_HWAIT,
		ST_HUPD
	} state_t;

endpackage

>>> rtl/pcf_ram.sv
// Generic single-port synchronous RAM with registered read.
// Standalone; used for the angle and value tables.
module pcf_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> rtl/pcf_div.sv
// Iterative restoring divider, four quotient bits per cycle, saturating quotient.
// Depends on pcf_pkg (div_req_t, div_rsp_t, widths).
module pcf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pcf_pkg::div_req_t req,
	output pcf_pkg::div_rsp_t rsp
);

	localparam int unsigned DVW   = 96;
	localparam int unsigned STEPS = 4;
	localparam int unsigned CYC   = DVW / STEPS;
	localparam int unsigned CW    = $clog2(CYC + 1);

	logic [DVW-1:0]         dvd_q;
	logic [pcf_pkg::XW:0]   rem_q;
	logic [pcf_pkg::XW-1:0] x_q;
	logic [pcf_pkg::QW-1:0] quo_q;
	logic                   sat_q;
	logic [CW-1:0]          cnt_q;
	logic                   run_q;
	logic                   done_q;

	logic [pcf_pkg::XW:0]   rem_d;
	logic [pcf_pkg::QW-1:0] quo_d;
	logic                   sat_d;

	always_comb begin
		rem_d = rem_q;
		quo_d = quo_q;
		sat_d = sat_q;
		for (int b = 0; b < STEPS; b++) begin
			rem_d = {rem_d[pcf_pkg::XW-1:0], dvd_q[DVW-1-b]};
			// a bit shifted out of the quotient means it passed 2^61 - 1
			sat_d = sat_d | quo_d[pcf_pkg::QW-1];
			quo_d = {quo_d[pcf_pkg::QW-2:0], 1'b0};
			if (rem_d >= {1'b0, x_q}) begin
				rem_d    = rem_d - {1'b0, x_q};
				quo_d[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CW'(CYC - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			if (req.frac) begin
				dvd_q <= {{(DVW-pcf_pkg::NW-pcf_pkg::FRAC){1'b0}}, req.n,
					{pcf_pkg::FRAC{1'b0}}};
			end else begin
				dvd_q <= {{(DVW-pcf_pkg::NW){1'b0}}, req.n};
			end
			x_q   <= req.x;
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DVW-STEPS-1:0], {STEPS{1'b0}}};
			rem_q <= rem_d;
			quo_q <= quo_d;
			sat_q <= sat_d;
		end
	end

	assign rsp.done = done_q;
	assign rsp.q    = sat_q ? {pcf_pkg::QW{1'b1}} : quo_q;

endmodule

>>> rtl/pcf_mul.sv
// Multi-cycle unsigned multiplier: 61 x 35 bits in two 32 x 35 partial products,
// result scaled down by 2^29 and saturated. Depends on pcf_pkg.
module pcf_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  pcf_pkg::mul_req_t req,
	output pcf_pkg::mul_rsp_t rsp
);

	localparam int unsigned PW = 32 + pcf_pkg::MB;
	localparam int unsigned AW = 96;

	logic [pcf_pkg::MA-1:0] a_q;
	logic [pcf_pkg::MB-1:0] b_q;
	logic [PW-1:0]          prod_q;
	logic [AW-1:0]          acc_q;
	logic [1:0]             ph_q;
	logic                   done_q;
	logic [31:0]            op_a;

	assign op_a = (ph_q == 2'd1) ? a_q[31:0] : 32'(a_q[pcf_pkg::MA-1:32]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= (ph_q == 2'd3);
			if (req.start) begin
				ph_q <= 2'd1;
			end else if (ph_q != 2'd0) begin
				ph_q <= ph_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end
		if (ph_q == 2'd1 || ph_q == 2'd2) begin
			prod_q <= op_a * b_q;
		end
		if (ph_q == 2'd2) begin
			acc_q <= AW'(prod_q);
		end else if (ph_q == 2'd3) begin
			acc_q <= acc_q + AW'({prod_q, 32'd0});
		end
	end

	assign rsp.done = done_q;
	assign rsp.m    = (|acc_q[AW-1:pcf_pkg::QW+pcf_pkg::FRAC]) ? {pcf_pkg::QW{1'b1}}
		: acc_q[pcf_pkg::QW+pcf_pkg::FRAC-1:pcf_pkg::FRAC];

endmodule

>>> rtl/periodic_cubic_fit_derivatives.sv
// Periodic cubic fit: node table in two RAMs, a sequencer, a shared divider and multiplier.
// Depends on pcf_pkg, pcf_ram, pcf_div and pcf_mul.
//
// A node write (op 0) goes straight into the tables and busy stays low. A query (op 1) holds
// busy through one division for the grid index, six table reads and four setup steps, six
// divisions for the divided differences, nine multiplies and three updates for the nested
// evaluation; most of the busy time goes to the shared divider. A singular stencil ends the
// query after the check. Each result is shown for one cycle with result_valid and cannot be
// held off; the next item can be started in the same cycle.
// Registers are written only while busy is low. Table entries read by a query must have
// been written before.
module periodic_cubic_fit_derivatives #(
	parameter int unsigned MAX_NODES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                op,
	input  logic [9:0]          node_index,
	input  logic [31:0]         node_angle,
	input  logic signed [31:0]  node_value,
	input  logic [31:0]         query_angle,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_data,
	output logic                result_valid,
	output logic signed [47:0]  fit_value,
	output logic signed [47:0]  first_deriv,
	output logic signed [47:0]  second_deriv,
	output logic                singular
);

	localparam int unsigned AW = $clog2(MAX_NODES);
	localparam int unsigned KW = $clog2(MAX_NODES + 1);
	localparam int unsigned DW = 34;
	localparam int unsigned FW = 62;
	localparam logic signed [FW-1:0] ILIM = {1'b0, {(FW-1){1'b1}}};
	localparam logic signed [FW:0]   ILIM_W = {2'b00, {(FW-1){1'b1}}};

	function automatic logic signed [FW-1:0] addc(input logic signed [FW-1:0] a,
		input logic signed [FW-1:0] b);
		logic signed [FW:0] s;
		s = {a[FW-1], a} + {b[FW-1], b};
		if (s > ILIM_W) begin
			return ILIM;
		end
		if (s < -ILIM_W) begin
			return -ILIM;
		end
		return s[FW-1:0];
	endfunction

	function automatic logic signed [47:0] out48(input logic signed [FW-1:0] v);
		if (v > FW'(signed'(48'sh7FFF_FFFF_FFFF))) begin
			return 48'sh7FFF_FFFF_FFFF;
		end
		if (v < FW'(signed'(48'sh8000_0000_0000))) begin
			return 48'sh8000_0000_0000;
		end
		return v[47:0];
	endfunction

	// configuration
	logic [31:0] grid_spacing_q;
	logic [10:0] node_count_q;
	logic [31:0] delta;
	logic [KW-1:0] kmax;

	// state
	pcf_pkg::state_t state_q, state_d;

	assign cfg_ready = (state_q == pcf_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_spacing_q <= 32'd3294198;
			node_count_q   <= 11'd1024;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pcf_pkg::CFG_GRID_SPACING: grid_spacing_q <= cfg_data;
				pcf_pkg::CFG_NODE_COUNT:   node_count_q   <= cfg_data[10:0];
			endcase
		end
	end

	assign delta = (grid_spacing_q == 32'd0) ? 32'd1 : grid_spacing_q;

	always_comb begin
		if (node_count_q < 11'd5) begin
			kmax = KW'(5);
		end else if (32'(node_count_q) > MAX_NODES) begin
			kmax = KW'(MAX_NODES);
		end else begin
			kmax = KW'(node_count_q);
		end
	end

	pcf_pkg::div_req_t div_req;
	pcf_pkg::div_rsp_t div_rsp;
	pcf_pkg::mul_req_t mul_req;
	pcf_pkg::mul_rsp_t mul_rsp;

	logic [31:0]   s_q;
	logic [KW-1:0] k_q;
	logic          wrap_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] cmp_addr_q;
	logic [2:0]    rd_cnt_q;
	logic          rd_vld_s1;
	logic [2:0]    rd_slot_s1;
	logic [31:0]   acmp_q;
	logic [31:0]   ta_q [5];
	logic [31:0]   va_q [5];
	logic signed [DW-1:0] d_q [4];
	logic signed [FW-1:0] f_q [4];
	logic [2:0]    step_q;
	logic [1:0]    tgt_q;
	logic          neg_q;
	logic [1:0]    hi_q;
	logic [1:0]    mph_q;
	logic signed [FW-1:0] m_q [3];
	logic signed [FW-1:0] p_q, p1_q, p2_q;
	logic          res_vld_q;
	logic signed [47:0] fit_q, d1_q, d2_q;
	logic          sing_q;

	// RAMs: writes only in idle, reads only while busy, so the same entry never overlaps
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0]   ang_rd;
	logic [31:0]   val_rd;

	pcf_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_angle_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(node_angle), .rdata(ang_rd)
	);

	pcf_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_value_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(node_value), .rdata(val_rd)
	);

	pcf_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));
	pcf_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));

	// stencil preparation
	logic [33:0]   cmpv;
	logic          first;
	logic [31:0]   tt [5];
	logic [31:0]   vv [4];
	logic          any_lo, any_hi;
	logic signed [DW-1:0] tu [5];
	logic signed [DW-1:0] dn [4];
	logic signed [FW-1:0] fn [4];
	logic          sing_now;

	always_comb begin
		cmpv  = wrap_q ? (34'(acmp_q) + pcf_pkg::TWO_PI) : 34'(acmp_q);
		first = 34'(s_q) > cmpv;
		for (int i = 0; i < 4; i++) begin
			tt[i] = first ? ta_q[i+1] : ta_q[i];
			vv[i] = first ? va_q[i+1] : va_q[i];
		end
		tt[4]  = s_q;
		any_lo = 1'b0;
		any_hi = 1'b0;
		for (int i = 0; i < 5; i++) begin
			any_lo = any_lo | (tt[i] < pcf_pkg::QUARTER_PI);
			any_hi = any_hi | (tt[i] > pcf_pkg::HIGH_EDGE);
		end
		// unwrap across 2*pi when the stencil straddles zero
		for (int i = 0; i < 5; i++) begin
			tu[i] = $signed({2'b00, tt[i]});
			if (any_lo && any_hi && tt[i] > pcf_pkg::HIGH_EDGE) begin
				tu[i] = tu[i] - $signed(pcf_pkg::TWO_PI);
			end
		end
		for (int i = 0; i < 4; i++) begin
			dn[i] = tu[i] - tu[4];
			fn[i] = $signed({{22{vv[i][31]}}, vv[i], 8'd0});
		end
		sing_now = (d_q[0] == d_q[1]) || (d_q[0] == d_q[2]) || (d_q[0] == d_q[3])
			|| (d_q[1] == d_q[2]) || (d_q[1] == d_q[3]) || (d_q[2] == d_q[3]);
	end

	// divided-difference operands: f[i] - f[i-1] over d[i] - d[i-j]
	logic signed [FW-1:0] fa, fb;
	logic signed [DW-1:0] da, dc;
	logic [1:0]           tgt_d;
	logic signed [FW:0]   num;
	logic signed [DW:0]   den;

	always_comb begin
		fa = '0; fb = '0; da = '0; dc = '0; tgt_d = 2'd3;
		unique case (step_q)
			3'd0: begin fa = f_q[3]; fb = f_q[2]; da = d_q[3]; dc = d_q[2]; tgt_d = 2'd3; end
			3'd1: begin fa = f_q[2]; fb = f_q[1]; da = d_q[2]; dc = d_q[1]; tgt_d = 2'd2; end
			3'd2: begin fa = f_q[1]; fb = f_q[0]; da = d_q[1]; dc = d_q[0]; tgt_d = 2'd1; end
			3'd3: begin fa = f_q[3]; fb = f_q[2]; da = d_q[3]; dc = d_q[1]; tgt_d = 2'd3; end
			3'd4: begin fa = f_q[2]; fb = f_q[1]; da = d_q[2]; dc = d_q[0]; tgt_d = 2'd2; end
			3'd5: begin fa = f_q[3]; fb = f_q[2]; da = d_q[3]; dc = d_q[0]; tgt_d = 2'd3; end
			default: begin end
		endcase
		num = {fa[FW-1], fa} - {fb[FW-1], fb};
		den = {da[DW-1], da} - {dc[DW-1], dc};
	end

	// nested evaluation operands
	logic signed [DW:0]   e;
	logic signed [FW-1:0] msel;
	logic signed [FW-1:0] q_signed;
	logic signed [FW-1:0] m_signed;
	logic signed [FW-1:0] np, np1, np2;

	always_comb begin
		e = -{d_q[hi_q][DW-1], d_q[hi_q]};
		unique case (mph_q)
			2'd0:    msel = p2_q;
			2'd1:    msel = p1_q;
			default: msel = p_q;
		endcase
		q_signed = neg_q ? -$signed({1'b0, div_rsp.q}) : $signed({1'b0, div_rsp.q});
		m_signed = neg_q ? -$signed({1'b0, mul_rsp.m}) : $signed({1'b0, mul_rsp.m});
		np2 = addc(m_q[0], addc(p1_q, p1_q));
		np1 = addc(m_q[1], p_q);
		np  = addc(f_q[hi_q], m_q[2]);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pcf_pkg::ST_IDLE:  if (start && op == pcf_pkg::OP_QUERY) state_d = pcf_pkg::ST_KDIV;
			pcf_pkg::ST_KDIV:  state_d = pcf_pkg::ST_KWAIT;
			pcf_pkg::ST_KWAIT: if (div_rsp.done) state_d = pcf_pkg::ST_KSET;
			pcf_pkg::ST_KSET:  state_d = pcf_pkg::ST_READ;
			pcf_pkg::ST_READ:  if (rd_cnt_q == 3'd5) state_d = pcf_pkg::ST_RLAST;
			pcf_pkg::ST_RLAST: state_d = pcf_pkg::ST_PREP;
			pcf_pkg::ST_PREP:  state_d = pcf_pkg::ST_CHECK;
			pcf_pkg::ST_CHECK: state_d = sing_now ? pcf_pkg::ST_IDLE : pcf_pkg::ST_DDIV;
			pcf_pkg::ST_DDIV:  state_d = pcf_pkg::ST_DWAIT;
			pcf_pkg::ST_DWAIT: begin
				if (div_rsp.done) begin
					state_d = (step_q == 3'd5) ? pcf_pkg::ST_HMUL : pcf_pkg::ST_DDIV;
				end
			end
			pcf_pkg::ST_HMUL:  state_d = pcf_pkg::ST_HWAIT;
			pcf_pkg::ST_HWAIT: begin
				if (mul_rsp.done) begin
					state_d = (mph_q == 2'd2) ? pcf_pkg::ST_HUPD : pcf_pkg::ST_HMUL;
				end
			end
			pcf_pkg::ST_HUPD:  state_d = (hi_q == 2'd0) ? pcf_pkg::ST_IDLE : pcf_pkg::ST_HMUL;
			default:           state_d = pcf_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy          = (state_q != pcf_pkg::ST_IDLE);
		ram_we        = (state_q == pcf_pkg::ST_IDLE) && start && op == pcf_pkg::OP_WRITE
			&& (32'(node_index) < MAX_NODES);
		ram_addr      = AW'(node_index);
		div_req       = '0;
		mul_req       = '0;
		if (state_q == pcf_pkg::ST_READ) begin
			ram_addr = (rd_cnt_q == 3'd0) ? cmp_addr_q : ptr_q;
		end
		if (state_q == pcf_pkg::ST_KDIV) begin
			div_req.start = 1'b1;
			div_req.frac  = 1'b0;
			div_req.n     = pcf_pkg::NW'(34'({s_q, 1'b0}) + 34'(delta));
			div_req.x     = pcf_pkg::XW'({delta, 1'b0});
		end
		if (state_q == pcf_pkg::ST_DDIV) begin
			div_req.start = 1'b1;
			div_req.frac  = 1'b1;
			div_req.n     = num[FW] ? pcf_pkg::NW'(-num) : pcf_pkg::NW'(num);
			div_req.x     = den[DW] ? pcf_pkg::XW'(-den) : pcf_pkg::XW'(den);
		end
		if (state_q == pcf_pkg::ST_HMUL) begin
			mul_req.start = 1'b1;
			mul_req.a     = msel[FW-1] ? pcf_pkg::MA'(-msel) : pcf_pkg::MA'(msel);
			mul_req.b     = e[DW] ? pcf_pkg::MB'(-e) : pcf_pkg::MB'(e);
		end
	end

	// control registers
	logic [KW:0] base;
	assign base = (KW+1)'(k_q) + (KW+1)'(kmax) - (KW+1)'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pcf_pkg::ST_IDLE;
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
			step_q    <= '0;
			hi_q      <= '0;
			mph_q     <= '0;
			res_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == pcf_pkg::ST_READ);
			res_vld_q <= ((state_q == pcf_pkg::ST_CHECK) && sing_now)
				|| ((state_q == pcf_pkg::ST_HUPD) && hi_q == 2'd0);
			if (state_q == pcf_pkg::ST_KSET) begin
				rd_cnt_q <= '0;
			end else if (state_q == pcf_pkg::ST_READ) begin
				rd_cnt_q <= rd_cnt_q + 3'd1;
			end
			if (state_q == pcf_pkg::ST_CHECK) begin
				step_q <= '0;
			end else if (state_q == pcf_pkg::ST_DWAIT && div_rsp.done) begin
				step_q <= step_q + 3'd1;
			end
			if (state_q == pcf_pkg::ST_DWAIT && div_rsp.done && step_q == 3'd5) begin
				hi_q  <= 2'd2;
				mph_q <= 2'd0;
			end else if (state_q == pcf_pkg::ST_HWAIT && mul_rsp.done && mph_q != 2'd2) begin
				mph_q <= mph_q + 2'd1;
			end else if (state_q == pcf_pkg::ST_HUPD) begin
				hi_q  <= hi_q - 2'd1;
				mph_q <= 2'd0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rd_slot_s1 <= rd_cnt_q;
		if (state_q == pcf_pkg::ST_IDLE && start) begin
			s_q <= query_angle;
		end
		if (state_q == pcf_pkg::ST_KWAIT && div_rsp.done) begin
			k_q <= (div_rsp.q > pcf_pkg::QW'(kmax)) ? kmax : KW'(div_rsp.q);
		end
		if (state_q == pcf_pkg::ST_KSET) begin
			wrap_q     <= (k_q == kmax);
			cmp_addr_q <= (k_q == kmax) ? AW'(0) : AW'(k_q);
			ptr_q      <= (base >= (KW+1)'(kmax)) ? AW'(base - (KW+1)'(kmax)) : AW'(base);
		end else if (state_q == pcf_pkg::ST_READ && rd_cnt_q != 3'd0) begin
			ptr_q <= (ptr_q == AW'(kmax - KW'(1))) ? AW'(0) : ptr_q + AW'(1);
		end
		if (rd_vld_s1) begin
			if (rd_slot_s1 == 3'd0) begin
				acmp_q <= ang_rd;
			end else begin
				ta_q[rd_slot_s1 - 3'd1] <= ang_rd;
				va_q[rd_slot_s1 - 3'd1] <= val_rd;
			end
		end
		if (state_q == pcf_pkg::ST_PREP) begin
			for (int i = 0; i < 4; i++) begin
				d_q[i] <= dn[i];
				f_q[i] <= fn[i];
			end
		end
		if (state_q == pcf_pkg::ST_DDIV) begin
			tgt_q <= tgt_d;
			neg_q <= num[FW] ^ den[DW];
		end
		if (state_q == pcf_pkg::ST_HMUL) begin
			neg_q <= msel[FW-1] ^ e[DW];
		end
		if (state_q == pcf_pkg::ST_DWAIT && div_rsp.done) begin
			f_q[tgt_q] <= q_signed;
			if (step_q == 3'd5) begin
				p_q  <= q_signed;
				p1_q <= '0;
				p2_q <= '0;
			end
		end
		if (state_q == pcf_pkg::ST_HWAIT && mul_rsp.done) begin
			m_q[mph_q] <= m_signed;
		end
		if (state_q == pcf_pkg::ST_HUPD) begin
			p_q  <= np;
			p1_q <= np1;
			p2_q <= np2;
			if (hi_q == 2'd0) begin
				fit_q  <= out48(np);
				d1_q   <= out48(np1);
				d2_q   <= out48(np2);
				sing_q <= 1'b0;
			end
		end
		if (state_q == pcf_pkg::ST_CHECK && sing_now) begin
			fit_q  <= '0;
			d1_q   <= '0;
			d2_q   <= '0;
			sing_q <= 1'b1;
		end
	end

	assign result_valid = res_vld_q;
	assign fit_value    = fit_q;
	assign first_deriv  = d1_q;
	assign second_deriv = d2_q;
	assign singular     = sing_q;

`ifndef SYNTHESIS
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && singular) |-> (fit_value == '0 && first_deriv == '0
			&& second_deriv == '0))
		else $error("singular result carries nonzero values");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == pcf_pkg::ST_KWAIT || state_q == pcf_pkg::ST_DWAIT))
		else $error("divider finished outside a wait state");
	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == pcf_pkg::ST_HWAIT))
		else $error("multiplier finished outside its wait state");
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !busy)
		else $error("table written while a query runs");
`endif

endmodule
